[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Operation codes, error codes, controller states and the control group
// that the queue controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package dq_pkg;

   // Widths fixed by the item format.
   localparam int VALUE_WIDTH = 32;
   localparam int MODE_WIDTH  = 3;
   localparam int ERROR_WIDTH = 2;

   // Default geometry.
   localparam int DEFAULT_DEPTH      = 16;
   localparam int DEFAULT_DATA_WIDTH = 32;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_REAR  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_REAR   = 3'd3,
      MODE_STATUS     = 3'd4
   } mode_type;

   typedef enum logic [ERROR_WIDTH-1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_READ = 2'd1,
      ST_SEND = 2'd2
   } state_type;

   // Control broadcast to the cell chain for one chain update.
   typedef struct packed {
      logic shift_rearward;  // push at the front: every entry moves one cell back
      logic shift_frontward; // pop at the front: every entry moves one cell forward
      logic write_rear;      // push at the rear: the cell just past the rear loads
   } cell_ctl_type;

endpackage

[rtl/dq_cell.sv]
// ----------------------------------------------------------------------------
// dq_cell: one storage cell of the queue chain
// Holds one entry and trades it with its neighbors as the queue shifts.
// Also flags itself when it holds the rear entry.
// ----------------------------------------------------------------------------
module dq_cell #(
   parameter int DATA_WIDTH  = dq_pkg::DEFAULT_DATA_WIDTH,
   parameter int COUNT_WIDTH = 5,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  dq_pkg::cell_ctl_type   ctl,
   input  logic [COUNT_WIDTH-1:0] count,      // entries held now
   input  logic [COUNT_WIDTH-1:0] rear_pos,   // position of the rear entry
   input  logic [DATA_WIDTH-1:0]  push_data,
   input  logic [DATA_WIDTH-1:0]  front_data, // from the neighbor nearer the front
   input  logic [DATA_WIDTH-1:0]  rear_data,  // from the neighbor nearer the rear
   output logic [DATA_WIDTH-1:0]  data,
   output logic [DATA_WIDTH-1:0]  rear_tap    // data when this cell is the rear, else 0
);
   import dq_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] MyPos = COUNT_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.shift_rearward) begin
         data_in = front_data;
      end else if (ctl.shift_frontward) begin
         data_in = rear_data;
      end else if (ctl.write_rear && (count == MyPos)) begin
         data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign rear_tap = (rear_pos == MyPos) ? data_ff : '0;

endmodule

[rtl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top: bounded double-ended queue built as a cell chain
// The queue keeps up to DEPTH entries in a row of cells, with the front entry
// always in the first cell. Each request item pushes or pops at either end,
// or only asks for status, and returns exactly one response item carrying the
// front and rear values, the entry count, empty and full flags and an error
// code. A pop on an empty queue or a push on a full one is refused and leaves
// the queue as it was. One item is handled at a time, in the steps accept and
// update the chain, read both ends, and present the response, which waits
// while the response channel stalls; the read of the rear end through the
// chain's select tree has a step of its own.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
   parameter int DEPTH      = dq_pkg::DEFAULT_DEPTH,
   parameter int DATA_WIDTH = dq_pkg::DEFAULT_DATA_WIDTH,
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [dq_pkg::MODE_WIDTH-1:0]       req_mode,
   input  logic signed [dq_pkg::VALUE_WIDTH-1:0] req_value,
   // Response channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [dq_pkg::VALUE_WIDTH-1:0] rsp_front_value,
   output logic signed [dq_pkg::VALUE_WIDTH-1:0] rsp_rear_value,
   output logic [CountWidth-1:0]               rsp_entry_count,
   output logic                                rsp_is_empty,
   output logic                                rsp_is_full,
   output logic [dq_pkg::ERROR_WIDTH-1:0]      rsp_error_code
);
   import dq_pkg::*;

   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   // Controller state.
   state_type state_ff, state_in;
   logic [CountWidth-1:0] count_ff, count_in;
   error_type error_ff, error_in;

   // Handshake and sequencing strobes from the output decode.
   logic accept;
   logic load_rsp;

   // Cell chain wiring.
   cell_ctl_type ctl;
   logic [DATA_WIDTH-1:0] push_data;
   logic [CountWidth-1:0] rear_pos;
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
   logic [DATA_WIDTH-1:0] rear_sel;

   // Response registers.
   logic signed [VALUE_WIDTH-1:0] rsp_front_ff, rsp_front_in;
   logic signed [VALUE_WIDTH-1:0] rsp_rear_ff, rsp_rear_in;
   logic [CountWidth-1:0] rsp_count_ff;
   logic rsp_empty_ff, rsp_full_ff;
   error_type rsp_error_ff;

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            load_rsp = 1'b1;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign accept = req_valid && !req_stall;

   // Decode the accepted request into chain control, a new count and an
   // error code. Unused mode codes behave as a status request.
   always_comb begin
      ctl      = '0;
      count_in = count_ff;
      error_in = error_ff;
      if (accept) begin
         error_in = ERR_OK;
         case (req_mode)
            MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
               if (count_ff == FullCount) begin
                  error_in = ERR_OVERFLOW;
               end else begin
                  ctl.shift_rearward = (req_mode == MODE_PUSH_FRONT);
                  ctl.write_rear     = (req_mode == MODE_PUSH_REAR);
                  count_in           = count_ff + 1'b1;
               end
            end
            MODE_POP_FRONT, MODE_POP_REAR: begin
               if (count_ff == '0) begin
                  error_in = ERR_UNDERFLOW;
               end else begin
                  ctl.shift_frontward = (req_mode == MODE_POP_FRONT);
                  count_in            = count_ff - 1'b1;
               end
            end
            default: begin
               error_in = ERR_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         error_ff <= ERR_OK;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

   // The store keeps the low DATA_WIDTH bits of the pushed value.
   assign push_data = DATA_WIDTH'($unsigned(req_value));
   // The rear entry sits one cell before the count; with an empty queue
   // this points nowhere useful and the response masks it.
   assign rear_pos  = count_ff - 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] from_front;
      logic [DATA_WIDTH-1:0] from_rear;

      if (i == 0) begin : g_head
         assign from_front = push_data;
      end else begin : g_body
         assign from_front = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign from_rear = cell_data[i];
      end else begin : g_mid
         assign from_rear = cell_data[i+1];
      end

      dq_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .COUNT_WIDTH(CountWidth),
         .INDEX      (i)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .count     (count_ff),
         .rear_pos  (rear_pos),
         .push_data (push_data),
         .front_data(from_front),
         .rear_data (from_rear),
         .data      (cell_data[i]),
         .rear_tap  (cell_tap[i])
      );
   end

   // Only the rear cell drives a nonzero tap, so an OR over the row picks it.
   always_comb begin
      rear_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rear_sel = rear_sel | cell_tap[i];
      end
   end

   // Both ends read as zero when the queue is empty.
   always_comb begin
      rsp_front_in = '0;
      rsp_rear_in  = '0;
      if (count_ff != '0) begin
         rsp_front_in = VALUE_WIDTH'(cell_data[0]);
         rsp_rear_in  = VALUE_WIDTH'(rear_sel);
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_front_ff <= rsp_front_in;
         rsp_rear_ff  <= rsp_rear_in;
         rsp_count_ff <= count_ff;
         rsp_empty_ff <= (count_ff == '0);
         rsp_full_ff  <= (count_ff == FullCount);
         rsp_error_ff <= error_ff;
      end
   end

   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;
   assign rsp_error_code  = rsp_error_ff;

endmodule

[tb/double_ended_queue_top_test.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top_test: self-checking bench for the double-ended queue
// Drives request items at both ends of the queue and keeps a ring-store model
// of its own in step with every accepted request. Each response item is
// checked field by field against the oldest predicted status. Directed
// tests cover the empty and full refusals, extreme values and the spare mode
// codes. Random traffic in several phases then fills, drains and churns the
// queue while both channels idle in random bursts until the final stretch.
// ----------------------------------------------------------------------------
module double_ended_queue_top_test;
   import dq_pkg::*;

   localparam int DEPTH       = DEFAULT_DEPTH;
   localparam int DATA_WIDTH  = DEFAULT_DATA_WIDTH;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   // Mode codes 5 to 7 have no operation of their own and act as status.
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [MODE_WIDTH-1:0] MODE_SPARE_LAST  = 3'd7;

   // Extreme values of the signed value field.
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = 32'sh7fff_ffff;

   // Cycles allowed after the last response before the run is closed.
   localparam int SETTLE_CYCLES = 8;

   // One predicted response item.
   typedef struct {
      logic signed [VALUE_WIDTH-1:0] front_value;
      logic signed [VALUE_WIDTH-1:0] rear_value;
      logic [COUNT_WIDTH-1:0]        entry_count;
      logic                          is_empty;
      logic                          is_full;
      error_type                     error_code;
   } queue_report_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [MODE_WIDTH-1:0]         req_mode;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [VALUE_WIDTH-1:0] rsp_front_value;
   logic signed [VALUE_WIDTH-1:0] rsp_rear_value;
   logic [COUNT_WIDTH-1:0]        rsp_entry_count;
   logic                          rsp_is_empty;
   logic                          rsp_is_full;
   logic [ERROR_WIDTH-1:0]        rsp_error_code;

   // Model of the queue: a ring of DEPTH slots with the front entry at
   // head_slot and the rear entry just below tail_slot.
   logic signed [VALUE_WIDTH-1:0] ring [DEPTH];
   int                            head_slot;
   int                            tail_slot;
   int                            held;

   // Predicted responses, oldest first.
   queue_report_type awaited_reports[$];
   queue_report_type oldest_report;

   // When set, neither the sender nor the receiver idles.
   bit idle_off;

   int fail_count;
   int items_sent;
   int reports_checked;
   int overflow_seen;
   int underflow_seen;
   int full_seen;

   double_ended_queue_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_error_code  (rsp_error_code)
   );

   // Free-running clock with a period of 10 time units.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous time limit: a correct run needs well under a tenth of this.
   initial begin
      #3_000_000;
      $display("Timeout at %0t with %0d responses outstanding.", $time,
               awaited_reports.size());
      $display("TEST FAILED");
      $finish;
   end

   // Applies one request to the model and returns the response that the
   // queue must give for it. A refused request leaves the model untouched.
   function automatic queue_report_type apply_request(input logic [MODE_WIDTH-1:0] mode,
                                                      input logic signed [VALUE_WIDTH-1:0] value);
      queue_report_type report;
      report.error_code = ERR_OK;
      case (mode)
         MODE_PUSH_FRONT, MODE_PUSH_REAR: begin
            if (held == DEPTH) begin
               report.error_code = ERR_OVERFLOW;
            end else if (mode == MODE_PUSH_FRONT) begin
               head_slot = (head_slot + DEPTH - 1) % DEPTH;
               ring[head_slot] = value;
               held++;
            end else begin
               ring[tail_slot] = value;
               tail_slot = (tail_slot + 1) % DEPTH;
               held++;
            end
         end
         MODE_POP_FRONT, MODE_POP_REAR: begin
            if (held == 0) begin
               report.error_code = ERR_UNDERFLOW;
            end else if (mode == MODE_POP_FRONT) begin
               head_slot = (head_slot + 1) % DEPTH;
               held--;
            end else begin
               tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
               held--;
            end
         end
         default: begin
            // Status and the spare codes change nothing.
         end
      endcase
      // Only held entries are ever shown, so no unwritten slot is read.
      if (held == 0) begin
         report.front_value = '0;
         report.rear_value  = '0;
      end else begin
         report.front_value = ring[head_slot];
         report.rear_value  = ring[(tail_slot + DEPTH - 1) % DEPTH];
      end
      report.entry_count = COUNT_WIDTH'(held);
      report.is_empty    = (held == 0);
      report.is_full     = (held == DEPTH);
      return report;
   endfunction

   // Compares one response field and reports a mismatch.
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Offers one request item, possibly after a random idle burst, and holds
   // it until it is accepted. The prediction is made at the accepting edge.
   // The valid is changed at most once per falling edge, so an item that
   // follows straight on keeps the valid high without a glitch.
   task automatic send_item(input logic [MODE_WIDTH-1:0] mode,
                            input logic signed [VALUE_WIDTH-1:0] value);
      int unsigned gap;
      gap = (!idle_off && $urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      awaited_reports.push_back(apply_request(mode, value));
      items_sent++;
   endtask

   // Holds the request channel idle until every predicted response is in.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_reports.size() != 0) @(posedge clock);
   endtask

   // Pops on an empty queue are refused; status on an empty queue shows zeros.
   task automatic test_empty_queue();
      send_item(MODE_STATUS, VALUE_MAX);
      send_item(MODE_POP_FRONT, VALUE_MIN);
      send_item(MODE_POP_REAR, 32'sd0);
   endtask

   // The most negative and most positive values travel through both ends.
   task automatic test_extreme_values();
      send_item(MODE_PUSH_FRONT, VALUE_MIN);
      send_item(MODE_PUSH_REAR, VALUE_MAX);
      send_item(MODE_POP_REAR, 32'sd0);
      send_item(MODE_POP_FRONT, 32'sd0);
   endtask

   // The spare mode codes must behave as status only, values ignored.
   task automatic test_spare_modes();
      logic [MODE_WIDTH-1:0] mode;
      send_item(MODE_PUSH_REAR, -32'sd1);
      for (mode = MODE_SPARE_FIRST; mode != MODE_SPARE_LAST; mode++) begin
         send_item(mode, VALUE_MIN);
      end
      send_item(MODE_SPARE_LAST, VALUE_MAX);
   endtask

   // Fills the queue from both ends, then pushes at each end of a full queue.
   task automatic test_full_queue();
      while (held < DEPTH) begin
         send_item((held % 2 == 0) ? MODE_PUSH_FRONT : MODE_PUSH_REAR, $urandom);
      end
      send_item(MODE_PUSH_FRONT, VALUE_MAX);
      send_item(MODE_PUSH_REAR, VALUE_MIN);
   endtask

   // Random traffic. The weights are percentages for pushes, pops and status;
   // whatever is left goes to the spare codes. Values are mostly random with
   // the extremes mixed in now and then.
   task automatic random_phase(input int count, input int push_pct, input int pop_pct,
                               input int status_pct);
      int                            pick;
      logic [MODE_WIDTH-1:0]         mode;
      logic signed [VALUE_WIDTH-1:0] value;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < push_pct) begin
            mode = $urandom_range(0, 1) ? MODE_PUSH_REAR : MODE_PUSH_FRONT;
         end else if (pick < push_pct + pop_pct) begin
            mode = $urandom_range(0, 1) ? MODE_POP_REAR : MODE_POP_FRONT;
         end else if (pick < push_pct + pop_pct + status_pct) begin
            mode = MODE_STATUS;
         end else begin
            mode = MODE_WIDTH'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
         end
         case ($urandom_range(0, 9))
            0:       value = VALUE_MIN;
            1:       value = VALUE_MAX;
            2:       value = '0;
            3:       value = -32'sd1;
            default: value = $urandom;
         endcase
         send_item(mode, value);
      end
   endtask

   // Drains from full, refills, churns near both limits, and closes with a
   // balanced stretch in which neither side idles.
   task automatic test_random_traffic();
      random_phase(220, 20, 70, 5);
      random_phase(220, 70, 20, 5);
      // Let the queue finish all work before carrying on.
      wait_for_drain();
      random_phase(280, 45, 45, 5);
      random_phase(150, 80, 15, 2);
      random_phase(130, 15, 80, 2);
      idle_off = 1'b1;
      random_phase(150, 48, 42, 5);
   endtask

   // Receiver side: the response channel stalls in random bursts until the
   // final stretch. Each falling edge sees at most one change of the stall.
   initial begin
      int unsigned burst;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!idle_off && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (burst) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_reports.size() == 0) begin
            $display("%0t: response with no request outstanding, front %h rear %h count %0d",
                     $time, rsp_front_value, rsp_rear_value, rsp_entry_count);
            fail_count++;
         end else begin
            oldest_report = awaited_reports[0];
            awaited_reports.delete(0);
            check_field("front_value", oldest_report.front_value, rsp_front_value);
            check_field("rear_value", oldest_report.rear_value, rsp_rear_value);
            check_field("entry_count", 32'(oldest_report.entry_count), 32'(rsp_entry_count));
            check_field("is_empty", 32'(oldest_report.is_empty), 32'(rsp_is_empty));
            check_field("is_full", 32'(oldest_report.is_full), 32'(rsp_is_full));
            check_field("error_code", 32'(oldest_report.error_code), 32'(rsp_error_code));
            reports_checked++;
            if (oldest_report.error_code == ERR_OVERFLOW) overflow_seen++;
            if (oldest_report.error_code == ERR_UNDERFLOW) underflow_seen++;
            if (oldest_report.is_full) full_seen++;
         end
      end
   end

   // Main sequence: reset once, run each test in turn, then wait for the
   // last responses and give the verdict.
   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_mode  = MODE_STATUS;
      req_value = '0;
      idle_off  = 1'b0;
      head_slot = 0;
      tail_slot = 0;
      held      = 0;
      fail_count      = 0;
      items_sent      = 0;
      reports_checked = 0;
      overflow_seen   = 0;
      underflow_seen  = 0;
      full_seen       = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extreme_values();
      test_spare_modes();
      test_full_queue();
      test_random_traffic();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d request items and checked %0d responses.", items_sent,
               reports_checked);
      $display("Refusals: %0d on a full queue, %0d on an empty one; %0d responses showed full.",
               overflow_seen, underflow_seen, full_seen);
      if (fail_count == 0 && awaited_reports.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[double_ended_queue_top.f]
rtl/dq_pkg.sv
rtl/dq_cell.sv
rtl/double_ended_queue_top.sv
tb/double_ended_queue_top_test.sv
